/* hdl/xsr_pkg.sv */
// Shared types and constants of the xoshiro256++ random generator.
package xsr_pkg;

   // Request kinds as carried in the request type field.
   typedef enum logic [1:0] {
      KIND_SEED     = 2'd0,
      KIND_RAW      = 2'd1,
      KIND_BOUNDED  = 2'd2,
      KIND_FRACTION = 2'd3
   } req_kind_type;

   // SplitMix64 constants.
   localparam logic [63:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_MUL_B    = 64'h94d049bb133111eb;
   localparam logic [63:0] ALL_ONES     = 64'hffffffffffffffff;

   // Controller states.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MIX_ADD,
      ST_XOR30,
      ST_MUL_A0,
      ST_MUL_A1,
      ST_MUL_A2,
      ST_XOR27,
      ST_MUL_B0,
      ST_MUL_B1,
      ST_MUL_B2,
      ST_XOR31,
      ST_REM_MAX,
      ST_WAIT_MAX,
      ST_DRAW,
      ST_CHECK,
      ST_WAIT_DRAW,
      ST_OUTPUT
   } ctrl_state_type;

   // Datapath operations.
   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_MIX_ADD,
      DP_XOR30,
      DP_XOR27,
      DP_XOR31_STORE,
      DP_MUL0,
      DP_MUL1,
      DP_MUL2,
      DP_REM_MAX,
      DP_SET_LIMIT,
      DP_DRAW,
      DP_REM_DRAW,
      DP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic       mul_sel;   // 0 selects the first mixing constant, 1 the second
      logic [1:0] word;      // state word written by a store
   } dp_cmd_type;

   typedef struct packed {
      req_kind_type kind;
      logic         bound_zero;
      logic         reject;
      logic         rem_busy;
      logic         out_busy;
   } dp_status_type;

endpackage

/* hdl/xsr_rem_unit.sv */
// Bit-serial remainder of a 64-bit dividend by a 32-bit divisor.
module xsr_rem_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        busy,
   output logic [31:0] rem
);
   import xsr_pkg::*;

   logic        busy_ff, busy_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] num_ff, num_in;
   logic [31:0] rem_ff, rem_in;
   logic [32:0] trial;
   logic [32:0] diff;

   // One restoring step per cycle, most significant dividend bit first.
   always_comb begin
      trial   = {rem_ff, num_ff[63]};
      diff    = trial - {1'b0, divisor};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd63;
         num_in  = dividend;
         rem_in  = 32'd0;
      end else if (busy_ff) begin
         num_in = {num_ff[62:0], 1'b0};
         rem_in = (trial >= {1'b0, divisor}) ? diff[31:0] : trial[31:0];
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign busy = busy_ff;
   assign rem  = rem_ff;

endmodule

/* hdl/xsr_datapath.sv */
// Generator state, SplitMix64 mixing, draw logic and result register.
module xsr_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  xsr_pkg::dp_cmd_type    cmd,
   output xsr_pkg::dp_status_type status,
   input  logic [1:0]             req_type,
   input  logic [63:0]            req_seed_value,
   input  logic [31:0]            req_bound,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [63:0]            rsp_value
);
   import xsr_pkg::*;

   logic [63:0]  s_ff [4];
   logic [63:0]  s_in [4];
   logic [63:0]  acc_ff, acc_in;
   logic [63:0]  w_ff, w_in;
   logic [63:0]  p_ff, p_in;
   logic [63:0]  d_ff, d_in;
   logic [63:0]  limit_ff, limit_in;
   logic [31:0]  bound_ff, bound_in;
   req_kind_type kind_ff, kind_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [63:0]  rsp_value_ff, rsp_value_in;

   logic [63:0]  mul_k;
   logic [31:0]  mul_x, mul_y;
   logic [63:0]  mul_p;
   logic [63:0]  draw_res, sum03, t2, t3, sh;
   logic [63:0]  n0, n1, n2, n3;
   logic [63:0]  result;
   logic         rem_start;
   logic [63:0]  rem_dividend;
   logic         rem_busy;
   logic [31:0]  rem;

   xsr_rem_unit u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (rem_dividend),
      .divisor  (bound_ff),
      .busy     (rem_busy),
      .rem      (rem)
   );

   // One xoshiro256++ step from the current state.
   always_comb begin
      sum03    = s_ff[0] + s_ff[3];
      draw_res = {sum03[40:0], sum03[63:41]} + s_ff[0];
      sh       = {s_ff[1][46:0], 17'd0};
      t2       = s_ff[2] ^ s_ff[0];
      t3       = s_ff[3] ^ s_ff[1];
      n1       = s_ff[1] ^ t2;
      n0       = s_ff[0] ^ t3;
      n2       = t2 ^ sh;
      n3       = {t3[18:0], t3[63:19]};
   end

   // A single 32 by 32 multiplier serves the three partial products.
   always_comb begin
      mul_k = cmd.mul_sel ? MIX_MUL_B : MIX_MUL_A;
      mul_x = w_ff[31:0];
      mul_y = mul_k[31:0];
      case (cmd.op)
         DP_MUL1: mul_y = mul_k[63:32];
         DP_MUL2: mul_x = w_ff[63:32];
         default: ;
      endcase
      mul_p = {32'd0, mul_x} * {32'd0, mul_y};
   end

   // Result selected by request kind.
   always_comb begin
      case (kind_ff)
         KIND_SEED:     result = 64'd0;
         KIND_RAW:      result = d_ff;
         KIND_BOUNDED:  result = (bound_ff == 32'd0) ? 64'd0 : {32'd0, rem};
         default:       result = {11'd0, d_ff[63:11]};
      endcase
   end

   // Register updates under the command of the controller.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         s_in[i] = s_ff[i];
      end
      acc_in       = acc_ff;
      w_in         = w_ff;
      p_in         = p_ff;
      d_in         = d_ff;
      limit_in     = limit_ff;
      bound_in     = bound_ff;
      kind_in      = kind_ff;
      rem_start    = 1'b0;
      rem_dividend = d_ff;
      rsp_value_in = rsp_value_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (cmd.op)
         DP_NOP: ;
         DP_LOAD: begin
            acc_in   = req_seed_value;
            bound_in = req_bound;
            kind_in  = req_kind_type'(req_type);
         end
         DP_MIX_ADD: begin
            acc_in = acc_ff + GOLDEN_GAMMA;
            w_in   = acc_ff + GOLDEN_GAMMA;
         end
         DP_XOR30:       w_in = w_ff ^ {30'd0, w_ff[63:30]};
         DP_XOR27:       w_in = w_ff ^ {27'd0, w_ff[63:27]};
         DP_XOR31_STORE: s_in[cmd.word] = w_ff ^ {31'd0, w_ff[63:31]};
         DP_MUL0:        p_in = mul_p;
         DP_MUL1:        p_in = p_ff + {mul_p[31:0], 32'd0};
         DP_MUL2:        w_in = p_ff + {mul_p[31:0], 32'd0};
         DP_REM_MAX: begin
            rem_start    = 1'b1;
            rem_dividend = ALL_ONES;
         end
         DP_SET_LIMIT:   limit_in = ALL_ONES - {32'd0, rem};
         DP_DRAW: begin
            d_in    = draw_res;
            s_in[0] = n0;
            s_in[1] = n1;
            s_in[2] = n2;
            s_in[3] = n3;
         end
         DP_REM_DRAW:    rem_start = 1'b1;
         DP_OUT: begin
            rsp_value_in = result;
            rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            s_ff[i] <= 64'd0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < 4; i++) begin
            s_ff[i] <= s_in[i];
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff       <= acc_in;
      w_ff         <= w_in;
      p_ff         <= p_in;
      d_ff         <= d_in;
      limit_ff     <= limit_in;
      bound_ff     <= bound_in;
      kind_ff      <= kind_in;
      rsp_value_ff <= rsp_value_in;
   end

   // Status back to the controller.
   always_comb begin
      status.kind       = kind_ff;
      status.bound_zero = (bound_ff == 32'd0);
      status.reject     = (d_ff >= limit_ff);
      status.rem_busy   = rem_busy;
      status.out_busy   = rsp_valid_ff && rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

endmodule

/* hdl/xsr_ctrl.sv */
// Controller state machine that sequences seeding, draws and rejection.
module xsr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  xsr_pkg::dp_status_type status,
   output xsr_pkg::dp_cmd_type    cmd
);
   import xsr_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic [1:0]     word_ff, word_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      word_in  = word_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_OUTPUT;
               word_in  = 2'd0;
            end
         end
         ST_MIX_ADD: state_in = ST_XOR30;
         ST_XOR30:   state_in = ST_MUL_A0;
         ST_MUL_A0:  state_in = ST_MUL_A1;
         ST_MUL_A1:  state_in = ST_MUL_A2;
         ST_MUL_A2:  state_in = ST_XOR27;
         ST_XOR27:   state_in = ST_MUL_B0;
         ST_MUL_B0:  state_in = ST_MUL_B1;
         ST_MUL_B1:  state_in = ST_MUL_B2;
         ST_MUL_B2:  state_in = ST_XOR31;
         ST_XOR31: begin
            word_in  = word_ff + 2'd1;
            state_in = (word_ff == 2'd3) ? ST_OUTPUT : ST_MIX_ADD;
         end
         ST_REM_MAX: state_in = ST_WAIT_MAX;
         ST_WAIT_MAX: begin
            if (!status.rem_busy) begin
               state_in = ST_DRAW;
            end
         end
         ST_DRAW: state_in = (status.kind == KIND_BOUNDED) ? ST_CHECK : ST_OUTPUT;
         ST_CHECK: state_in = status.reject ? ST_DRAW : ST_WAIT_DRAW;
         ST_WAIT_DRAW: begin
            if (!status.rem_busy) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (!status.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // The request kind is known once the item has been loaded.
      if (state_ff == ST_IDLE && req_valid) begin
         state_in = ST_IDLE;
      end
   end

   ctrl_state_type dispatch_in;
   logic           loaded_ff;

   // A loaded item is dispatched in the cycle after its transfer.
   always_comb begin
      dispatch_in = state_in;
      if (loaded_ff) begin
         unique case (status.kind)
            KIND_SEED:    dispatch_in = ST_MIX_ADD;
            KIND_BOUNDED: dispatch_in = status.bound_zero ? ST_OUTPUT : ST_REM_MAX;
            default:      dispatch_in = ST_DRAW;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         loaded_ff <= 1'b0;
      end else begin
         state_ff  <= dispatch_in;
         loaded_ff <= (state_ff == ST_IDLE) && req_valid && !loaded_ff;
      end
      word_ff <= word_in;
   end

   // Commands to the datapath.
   always_comb begin
      cmd.op      = DP_NOP;
      cmd.mul_sel = 1'b0;
      cmd.word    = word_ff;
      req_stall   = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = loaded_ff;
            if (req_valid && !loaded_ff) begin
               cmd.op = DP_LOAD;
            end
         end
         ST_MIX_ADD:   cmd.op = DP_MIX_ADD;
         ST_XOR30:     cmd.op = DP_XOR30;
         ST_MUL_A0:    cmd.op = DP_MUL0;
         ST_MUL_A1:    cmd.op = DP_MUL1;
         ST_MUL_A2:    cmd.op = DP_MUL2;
         ST_XOR27:     cmd.op = DP_XOR27;
         ST_MUL_B0: begin
            cmd.op      = DP_MUL0;
            cmd.mul_sel = 1'b1;
         end
         ST_MUL_B1: begin
            cmd.op      = DP_MUL1;
            cmd.mul_sel = 1'b1;
         end
         ST_MUL_B2: begin
            cmd.op      = DP_MUL2;
            cmd.mul_sel = 1'b1;
         end
         ST_XOR31:     cmd.op = DP_XOR31_STORE;
         ST_REM_MAX:   cmd.op = DP_REM_MAX;
         ST_WAIT_MAX: begin
            if (!status.rem_busy) begin
               cmd.op = DP_SET_LIMIT;
            end
         end
         ST_DRAW:      cmd.op = DP_DRAW;
         ST_CHECK: begin
            if (!status.reject) begin
               cmd.op = DP_REM_DRAW;
            end
         end
         ST_WAIT_DRAW: ;
         ST_OUTPUT: begin
            if (!status.out_busy) begin
               cmd.op = DP_OUT;
            end
         end
         default: ;
      endcase
   end

endmodule

/* hdl/xoshiro256pp_random_generator.sv */
// Top level of the xoshiro256++ random generator with SplitMix64 seeding.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  req_type, req_seed_value, req_bound
//   rsp       out        rsp_valid/rsp_stall  rsp_value
//
// One item at a time. A transfer loads the item, dispatched in the cycle after.
// Seeding runs four mixing rounds of an add, xor-shifts by 30, 27 and 31 and two
// multiplications on one shared 32 by 32 multiplier. Raw and fraction draws step
// the state once. Bounded draws with a nonzero bound run two 64-step serial
// remainders, one for the rejection limit and one for the result, and redraw on
// each rejection. Reset is synchronous and clears the state to zero; a result
// waiting on rsp_stall holds, and the next request is taken while it waits.
module xoshiro256pp_random_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [63:0] req_seed_value,
   input  logic [31:0] req_bound,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_value
);
   import xsr_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   xsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   xsr_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_type       (req_type),
      .req_seed_value (req_seed_value),
      .req_bound      (req_bound),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_value      (rsp_value)
   );

endmodule

/* sim/xoshiro256pp_random_generator_test.sv */
// Self-checking testbench for the xoshiro256++ random generator with SplitMix64 seeding.
`timescale 1ns / 100ps

module xoshiro256pp_random_generator_test;
   import xsr_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_type;
   logic [63:0] req_seed_value;
   logic [31:0] req_bound;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_value;

   // Predicted generator state and the queue of values still to arrive.
   logic [63:0] gen_word [4];
   logic [63:0] pending_values [$];

   int unsigned mismatch_count;
   int unsigned idle_cycles;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   bit          hold_receiver;
   bit          timed_out;

   xoshiro256pp_random_generator DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_seed_value(req_seed_value), .req_bound(req_bound),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_value(rsp_value)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic logic [63:0] rotl64(logic [63:0] v, int unsigned n);
      return (v << n) | (v >> (64 - n));
   endfunction

   // One SplitMix64 step on the running seed accumulator.
   function automatic logic [63:0] splitmix_next(ref logic [63:0] acc);
      logic [63:0] w;
      acc = acc + GOLDEN_GAMMA;
      w = acc;
      w = (w ^ (w >> 30)) * MIX_MUL_A;
      w = (w ^ (w >> 27)) * MIX_MUL_B;
      return w ^ (w >> 31);
   endfunction

   // One xoshiro256++ output, advancing the predicted state.
   function automatic logic [63:0] xoshiro_next();
      logic [63:0] res;
      logic [63:0] sh;
      res = rotl64(gen_word[0] + gen_word[3], 23) + gen_word[0];
      sh = gen_word[1] << 17;
      gen_word[2] ^= gen_word[0];
      gen_word[3] ^= gen_word[1];
      gen_word[1] ^= gen_word[2];
      gen_word[0] ^= gen_word[3];
      gen_word[2] ^= sh;
      gen_word[3] = rotl64(gen_word[3], 45);
      return res;
   endfunction

   function automatic logic [63:0] predict_value(req_kind_type kind, logic [63:0] seed,
                                                 logic [31:0] bnd);
      logic [63:0] acc;
      logic [63:0] limit;
      logic [63:0] d;
      case (kind)
         KIND_SEED: begin
            acc = seed;
            for (int i = 0; i < 4; i++) gen_word[i] = splitmix_next(acc);
            return 64'd0;
         end
         KIND_RAW: return xoshiro_next();
         KIND_BOUNDED: begin
            if (bnd == 32'd0) return 64'd0;
            limit = (ALL_ONES / {32'd0, bnd}) * {32'd0, bnd};
            do d = xoshiro_next(); while (d >= limit);
            return d % {32'd0, bnd};
         end
         default: return xoshiro_next() >> 11;
      endcase
   endfunction

   // Offer one request until it is taken, with random idle cycles first.
   // Valid stays high after the transfer until the next idle cycle or drain.
   task automatic send_request(req_kind_type kind, logic [63:0] seed, logic [31:0] bnd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_seed_value <= seed;
      req_bound <= bnd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_values.push_back(predict_value(kind, seed, bnd));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      wait (pending_values.size() == 0);
      @(negedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [31:0] rand_bound();
      case ($urandom_range(5))
         0: return $urandom_range(16);
         1: return 32'hffffffff - $urandom_range(4);
         2: return 32'd1 << $urandom_range(31);
         3: return (32'd1 << $urandom_range(31)) + 32'd1;
         default: return $urandom;
      endcase
   endfunction

   // Extremes, every request kind and the named special cases.
   task automatic test_directed();
      send_request(KIND_RAW, 64'd0, 32'd0);
      send_request(KIND_BOUNDED, 64'd0, 32'd7);
      send_request(KIND_FRACTION, 64'd0, 32'd0);
      send_request(KIND_SEED, 64'd0, 32'd0);
      send_request(KIND_RAW, ALL_ONES, 32'hffffffff);
      send_request(KIND_FRACTION, 64'd0, 32'd0);
      send_request(KIND_BOUNDED, 64'd0, 32'd0);
      send_request(KIND_BOUNDED, 64'd0, 32'd1);
      send_request(KIND_BOUNDED, 64'd0, 32'hffffffff);
      send_request(KIND_BOUNDED, 64'd0, 32'h80000001);
      send_request(KIND_SEED, ALL_ONES, 32'hffffffff);
      send_request(KIND_RAW, 64'd0, 32'd0);
      send_request(KIND_BOUNDED, ALL_ONES, 32'd3);
      send_request(KIND_SEED, 64'h8000000000000000, 32'd0);
      send_request(KIND_FRACTION, 64'd0, 32'd0);
      send_request(KIND_SEED, 64'd1, 32'd0);
      send_request(KIND_BOUNDED, 64'd0, 32'd2);
      send_request(KIND_RAW, 64'd0, 32'd0);
   endtask

   // Mostly draws on a seeded state, reseeded now and then with any seed.
   task automatic test_random(int unsigned count);
      req_kind_type kind;
      for (int unsigned n = 0; n < count; n++) begin
         kind = ($urandom_range(19) == 0) ? KIND_SEED : req_kind_type'($urandom_range(3));
         send_request(kind, rand64(), rand_bound());
      end
   endtask

   // Receiver holds off while the sender keeps offering, then the sender waits.
   task automatic test_backpressure();
      hold_receiver = 1'b1;
      fork
         begin
            repeat (400) @(negedge clock);
            hold_receiver = 1'b0;
         end
         for (int n = 0; n < 6; n++) send_request(KIND_RAW, rand64(), 32'd0);
      join
      wait_drained();
      test_random(10);
   endtask

   // Result checker against the oldest prediction.
   always @(posedge clock) begin
      logic [63:0] expected;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_values.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("Unexpected transfer: value %h", rsp_value);
         end else begin
            expected = pending_values.pop_front();
            if (rsp_value !== expected) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Value mismatch: expected %h, got %h", expected, rsp_value);
            end
         end
      end
   end

   // Receiver stall, random or held.
   always @(negedge clock) begin
      rsp_stall <= hold_receiver || ($urandom_range(99) < recv_idle_pct);
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000 && !timed_out) begin
         timed_out = 1'b1;
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = KIND_SEED;
      req_seed_value = 64'd0;
      req_bound = 32'd0;
      rsp_stall = 1'b0;
      hold_receiver = 1'b0;
      timed_out = 1'b0;
      mismatch_count = 0;
      idle_cycles = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < 4; i++) gen_word[i] = 64'd0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      send_idle_pct = 14;
      recv_idle_pct = 86;
      test_random(140);
      send_idle_pct = 86;
      recv_idle_pct = 14;
      test_random(140);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();
      test_random(140);

      wait_drained();
      repeat (200) @(negedge clock);
      if (mismatch_count == 0 && pending_values.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

/* sim.f */
hdl/xsr_pkg.sv
hdl/xsr_rem_unit.sv
hdl/xsr_datapath.sv
hdl/xsr_ctrl.sv
hdl/xoshiro256pp_random_generator.sv
sim/xoshiro256pp_random_generator_test.sv
